>>> rtl/core/pan_tilt_deadband_tracker_core_assert.svh
// Assertion macros for the pan/tilt deadband tracker core.
`ifndef PAN_TILT_DEADBAND_TRACKER_CORE_ASSERT_SVH
`define PAN_TILT_DEADBAND_TRACKER_CORE_ASSERT_SVH

`ifndef SYNTH
// Checked on aclk, switched off while aresetn is low.
`define PTTR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on aclk in every cycle, reset included.
`define PTTR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define PTTR_ASSERT(lbl, prop, msg)
`define PTTR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> rtl/core/pttr_pkg.sv
// Package: widths, constants, types and helper functions for the tracker core.
package pttr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int ANGLE_W        = 8;
    localparam int HIGH_W         = 12;
    localparam int PULSE_W        = 6;
    localparam int STEP_W         = 8;
    localparam int DB_W           = 8;
    localparam int CENTRE_W       = 12;
    localparam int ADDR_W         = 4;
    localparam int DATA_W         = 32;
    localparam int IDX_W          = 2;

    localparam logic [ANGLE_W-1:0] ANGLE_MAX    = 8'd180;
    localparam logic [ANGLE_W-1:0] ANGLE_HOME   = 8'd90;
    localparam logic [HIGH_W-1:0]  HIGH_BASE_US = 12'd546;

    // floor(10.3 * a) as (a * HIGH_MUL) >> HIGH_SHIFT; exact for a in 0..255
    localparam int HIGH_MUL_W  = 20;
    localparam logic [HIGH_MUL_W-1:0] HIGH_MUL = 20'd675021;
    localparam int HIGH_SHIFT  = 16;

    // floor(n / 9) as (n * PULSE_MUL) >> PULSE_SHIFT; exact for n below 369
    localparam int PULSE_NUM_W = 9;
    localparam int PULSE_MUL_W = 6;
    localparam logic [PULSE_MUL_W-1:0] PULSE_MUL = 6'd57;
    localparam int PULSE_SHIFT = 9;

    // register indexes
    localparam logic [IDX_W-1:0] REG_STEP_SIZE = 2'd0;
    localparam logic [IDX_W-1:0] REG_DEADBAND  = 2'd1;
    localparam logic [IDX_W-1:0] REG_CENTRE_X  = 2'd2;
    localparam logic [IDX_W-1:0] REG_CENTRE_Y  = 2'd3;

    localparam logic [STEP_W-1:0]   STEP_SIZE_RST = 8'd3;
    localparam logic [DB_W-1:0]     DEADBAND_RST  = 8'd20;
    localparam logic [CENTRE_W-1:0] CENTRE_X_RST  = 12'd640;
    localparam logic [CENTRE_W-1:0] CENTRE_Y_RST  = 12'd360;

    typedef struct packed {
        logic [STEP_W-1:0]   step_size;
        logic [DB_W-1:0]     deadband;
        logic [CENTRE_W-1:0] centre_x;
        logic [CENTRE_W-1:0] centre_y;
    } cfg_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [HIGH_W-1:0]  high_us;
        logic [PULSE_W-1:0] pulses;
    } axis_res_t;

    function automatic logic [HIGH_W-1:0] high_time(input logic [ANGLE_W-1:0] angle);
        logic [ANGLE_W+HIGH_MUL_W-1:0] prod;
        prod = {{HIGH_MUL_W{1'b0}}, angle} * {{ANGLE_W{1'b0}}, HIGH_MUL};
        high_time = prod[HIGH_SHIFT +: HIGH_W] + HIGH_BASE_US;
    endfunction

    // ceil(d * 40 / 180) = floor((2d + 8) / 9), d at most 180
    function automatic logic [PULSE_W-1:0] pulse_count(input logic [ANGLE_W-1:0] delta);
        logic [PULSE_NUM_W-1:0]             num;
        logic [PULSE_NUM_W+PULSE_MUL_W-1:0] prod;
        num  = {delta, 1'b0} + 9'd8;
        prod = {{PULSE_MUL_W{1'b0}}, num} * {{PULSE_NUM_W{1'b0}}, PULSE_MUL};
        pulse_count = prod[PULSE_SHIFT +: PULSE_W];
    endfunction

endpackage

>>> rtl/core/pan_tilt_deadband_tracker_core.sv
// Flow: a transaction accepted on s_ goes into the input register, then into
//   the result register once that is free, and shows on m_ from there.
// Throughput: one transaction per cycle while m_ready is high; input register and
//   result register each hold one item, so a new target is taken while a result waits.
// Reset: aresetn synchronous, active low; clears both stages, sets both
//   angles to 90 degrees and loads the register reset values.
`include "pan_tilt_deadband_tracker_core_assert.svh"

module pan_tilt_deadband_tracker_core #(
    parameter int COORD_BITS = pttr_pkg::COORD_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // target transactions
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [COORD_BITS-1:0]          s_target_x,
    input  logic [COORD_BITS-1:0]          s_target_y,
    // result transactions
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [pttr_pkg::ANGLE_W-1:0]   m_pan_deg,
    output logic [pttr_pkg::ANGLE_W-1:0]   m_tilt_deg,
    output logic [pttr_pkg::HIGH_W-1:0]    m_pan_high_us,
    output logic [pttr_pkg::HIGH_W-1:0]    m_tilt_high_us,
    output logic [pttr_pkg::PULSE_W-1:0]   m_pan_pulses,
    output logic [pttr_pkg::PULSE_W-1:0]   m_tilt_pulses,
    // configuration
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [pttr_pkg::ADDR_W-1:0]    paddr,
    input  logic [pttr_pkg::DATA_W-1:0]    pwdata,
    output logic [pttr_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);

    pttr_pkg::cfg_t       cfg;
    pttr_pkg::axis_res_t  pan_res, tilt_res;

    // stage 1: input register
    logic                   s1_valid_reg, s1_valid_next;
    logic [COORD_BITS-1:0]  s1_x_reg, s1_y_reg;

    // stage 2: result register
    logic                   m_valid_reg, m_valid_next;
    pttr_pkg::axis_res_t    m_pan_reg, m_tilt_reg;

    // kept servo angles
    logic [pttr_pkg::ANGLE_W-1:0] pan_pos_reg, pan_pos_next;
    logic [pttr_pkg::ANGLE_W-1:0] tilt_pos_reg, tilt_pos_next;

    logic out_free, s1_adv, s_acc;

    assign pready = 1'b1;

    pttr_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    // Handshake: the result register frees when empty or being taken;
    // stage 1 moves forward into it, and s_ready follows stage 1 space.
    assign out_free = !m_valid_reg || m_ready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_ready  = !s1_valid_reg || out_free;
    assign s_acc    = s_valid && s_ready;

    // Both axes work from the registered target and the kept angle.
    pttr_axis #(.COORD_BITS(COORD_BITS)) u_pan (
        .coord     (s1_x_reg),
        .centre    (cfg.centre_x),
        .step_size (cfg.step_size),
        .deadband  (cfg.deadband),
        .old_angle (pan_pos_reg),
        .res       (pan_res)
    );

    pttr_axis #(.COORD_BITS(COORD_BITS)) u_tilt (
        .coord     (s1_y_reg),
        .centre    (cfg.centre_y),
        .step_size (cfg.step_size),
        .deadband  (cfg.deadband),
        .old_angle (tilt_pos_reg),
        .res       (tilt_res)
    );

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_acc) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (s1_adv) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // angle state advances together with the result register load
    assign pan_pos_next  = s1_adv ? pan_res.angle  : pan_pos_reg;
    assign tilt_pos_next = s1_adv ? tilt_res.angle : tilt_pos_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            pan_pos_reg  <= pttr_pkg::ANGLE_HOME;
            tilt_pos_reg <= pttr_pkg::ANGLE_HOME;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
            pan_pos_reg  <= pan_pos_next;
            tilt_pos_reg <= tilt_pos_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_x_reg <= s_target_x;
            s1_y_reg <= s_target_y;
        end
        if (s1_adv) begin
            m_pan_reg  <= pan_res;
            m_tilt_reg <= tilt_res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pan_deg      = m_pan_reg.angle;
    assign m_tilt_deg     = m_tilt_reg.angle;
    assign m_pan_high_us  = m_pan_reg.high_us;
    assign m_tilt_high_us = m_tilt_reg.high_us;
    assign m_pan_pulses   = m_pan_reg.pulses;
    assign m_tilt_pulses  = m_tilt_reg.pulses;

    // a shown result always carries the angles now kept
    `PTTR_ASSERT(a_result_matches_state, m_valid_reg |-> (m_pan_reg.angle == pan_pos_reg && m_tilt_reg.angle == tilt_pos_reg), "result angle differs from kept angle")
    // kept angles move only when stage 1 hands over
    `PTTR_ASSERT(a_state_moves_on_adv, !s1_adv |=> ($stable(pan_pos_reg) && $stable(tilt_pos_reg)), "angle changed without a transaction")
    // kept angles stay in servo range
    `PTTR_ASSERT(a_angle_range, (pan_pos_reg <= pttr_pkg::ANGLE_MAX) && (tilt_pos_reg <= pttr_pkg::ANGLE_MAX), "angle out of range")
    // empty input stage can always take a transaction
    `PTTR_ASSERT_ALWAYS(a_ready_when_empty, !s1_valid_reg |-> s_ready, "input stage empty but not ready")

endmodule

>>> rtl/core/pttr_regs.sv
// Configuration register bank with APB-style access.
module pttr_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pttr_pkg::ADDR_W-1:0]   paddr,
    input  logic [pttr_pkg::DATA_W-1:0]   pwdata,
    output logic [pttr_pkg::DATA_W-1:0]   prdata,
    output pttr_pkg::cfg_t                cfg
);

    pttr_pkg::cfg_t cfg_reg;
    pttr_pkg::cfg_t cfg_next;
    logic [pttr_pkg::IDX_W-1:0] idx;
    logic                       wr_en;

    assign idx   = paddr[pttr_pkg::ADDR_W-1:2];
    assign wr_en = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (idx)
                pttr_pkg::REG_STEP_SIZE: cfg_next.step_size = pwdata[pttr_pkg::STEP_W-1:0];
                pttr_pkg::REG_DEADBAND:  cfg_next.deadband  = pwdata[pttr_pkg::DB_W-1:0];
                pttr_pkg::REG_CENTRE_X:  cfg_next.centre_x  = pwdata[pttr_pkg::CENTRE_W-1:0];
                pttr_pkg::REG_CENTRE_Y:  cfg_next.centre_y  = pwdata[pttr_pkg::CENTRE_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (idx)
            pttr_pkg::REG_STEP_SIZE: prdata = pttr_pkg::DATA_W'(cfg_reg.step_size);
            pttr_pkg::REG_DEADBAND:  prdata = pttr_pkg::DATA_W'(cfg_reg.deadband);
            pttr_pkg::REG_CENTRE_X:  prdata = pttr_pkg::DATA_W'(cfg_reg.centre_x);
            pttr_pkg::REG_CENTRE_Y:  prdata = pttr_pkg::DATA_W'(cfg_reg.centre_y);
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_size <= pttr_pkg::STEP_SIZE_RST;
            cfg_reg.deadband  <= pttr_pkg::DEADBAND_RST;
            cfg_reg.centre_x  <= pttr_pkg::CENTRE_X_RST;
            cfg_reg.centre_y  <= pttr_pkg::CENTRE_Y_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

>>> rtl/core/pttr_axis.sv
// One servo axis: deadband test, saturating step, high time and pulse count.
module pttr_axis #(
    parameter int COORD_BITS = pttr_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0]          coord,
    input  logic [pttr_pkg::CENTRE_W-1:0]  centre,
    input  logic [pttr_pkg::STEP_W-1:0]    step_size,
    input  logic [pttr_pkg::DB_W-1:0]      deadband,
    input  logic [pttr_pkg::ANGLE_W-1:0]   old_angle,
    output pttr_pkg::axis_res_t            res
);

    localparam int CMP_W = ((COORD_BITS > pttr_pkg::CENTRE_W) ?
                            COORD_BITS : pttr_pkg::CENTRE_W) + 1;

    logic [CMP_W-1:0]               c_ext, m_ext, db_ext;
    logic                           go_up, go_down;
    logic [pttr_pkg::ANGLE_W:0]     up_sum;
    logic [pttr_pkg::ANGLE_W-1:0]   up_angle, down_angle, new_angle, delta;

    assign c_ext  = CMP_W'(coord);
    assign m_ext  = CMP_W'(centre);
    assign db_ext = CMP_W'(deadband);

    // centre - deadband compared without going negative
    assign go_up   = c_ext > (m_ext + db_ext);
    assign go_down = (c_ext + db_ext) < m_ext;

    assign up_sum   = {1'b0, old_angle} + {1'b0, step_size};
    assign up_angle = (up_sum > {1'b0, pttr_pkg::ANGLE_MAX}) ?
                      pttr_pkg::ANGLE_MAX : up_sum[pttr_pkg::ANGLE_W-1:0];
    assign down_angle = (step_size > old_angle) ? '0 : (old_angle - step_size);

    always_comb begin
        if (go_up) begin
            new_angle = up_angle;
            delta     = up_angle - old_angle;
        end else if (go_down) begin
            new_angle = down_angle;
            delta     = old_angle - down_angle;
        end else begin
            new_angle = old_angle;
            delta     = '0;
        end
    end

    assign res.angle   = new_angle;
    assign res.high_us = pttr_pkg::high_time(new_angle);
    assign res.pulses  = pttr_pkg::pulse_count(delta);

endmodule

>>> tb/pan_tilt_deadband_tracker_checker.sv
// Checker: watches the target, result and register ports, predicts servo commands, compares.
`timescale 1ns / 100ps

module pan_tilt_deadband_tracker_checker #(
    parameter int COORD_BITS = pttr_pkg::COORD_BITS_DEF
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    input  logic                                    s_ready,
    input  logic [COORD_BITS-1:0]                   s_target_x,
    input  logic [COORD_BITS-1:0]                   s_target_y,
    input  logic                                    m_valid,
    input  logic                                    m_ready,
    input  logic [pttr_pkg::ANGLE_W-1:0]            m_pan_deg,
    input  logic [pttr_pkg::ANGLE_W-1:0]            m_tilt_deg,
    input  logic [pttr_pkg::HIGH_W-1:0]             m_pan_high_us,
    input  logic [pttr_pkg::HIGH_W-1:0]             m_tilt_high_us,
    input  logic [pttr_pkg::PULSE_W-1:0]            m_pan_pulses,
    input  logic [pttr_pkg::PULSE_W-1:0]            m_tilt_pulses,
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic                                    pready,
    input  logic [pttr_pkg::ADDR_W-1:0]             paddr,
    input  logic [pttr_pkg::DATA_W-1:0]             pwdata,
    output int                                      pending,
    output int                                      fail_count,
    output int                                      results_checked
);

    // high time is floor(10.3 * angle) + base, kept exact as 103/10
    localparam int HIGH_NUM = 103;
    localparam int HIGH_DEN = 10;

    typedef struct {
        logic [pttr_pkg::ANGLE_W-1:0] pan_deg;
        logic [pttr_pkg::ANGLE_W-1:0] tilt_deg;
        logic [pttr_pkg::HIGH_W-1:0]  pan_high_us;
        logic [pttr_pkg::HIGH_W-1:0]  tilt_high_us;
        logic [pttr_pkg::PULSE_W-1:0] pan_pulses;
        logic [pttr_pkg::PULSE_W-1:0] tilt_pulses;
    } servo_cmd_t;

    servo_cmd_t servo_cmd_q[$];
    servo_cmd_t cmd;
    servo_cmd_t want;

    logic [pttr_pkg::STEP_W-1:0]   cur_step;
    logic [pttr_pkg::DB_W-1:0]     cur_band;
    logic [pttr_pkg::CENTRE_W-1:0] cur_cx;
    logic [pttr_pkg::CENTRE_W-1:0] cur_cy;
    int pan_pos;
    int tilt_pos;
    int pan_new;
    int tilt_new;
    int errors;
    int checked;

    function automatic int next_angle(input int coord, input int centre, input int band,
                                      input int step, input int pos);
        int nxt;
        nxt = pos;
        if (coord > centre + band) begin
            nxt = pos + step;
            if (nxt > int'(pttr_pkg::ANGLE_MAX)) nxt = int'(pttr_pkg::ANGLE_MAX);
        end else if (coord < centre - band) begin
            nxt = pos - step;
            if (nxt < 0) nxt = 0;
        end
        return nxt;
    endfunction

    function automatic logic [pttr_pkg::HIGH_W-1:0] servo_high_us(input int angle);
        return pttr_pkg::HIGH_W'((angle * HIGH_NUM) / HIGH_DEN +
                                 int'(pttr_pkg::HIGH_BASE_US));
    endfunction

    // ceil(|delta| * 40 / 180)
    function automatic logic [pttr_pkg::PULSE_W-1:0] move_pulses(input int from, input int to);
        int d;
        d = (to > from) ? to - from : from - to;
        return pttr_pkg::PULSE_W'((2 * d + 8) / 9);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, exp_val);
        errors++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            cur_step = pttr_pkg::STEP_SIZE_RST;
            cur_band = pttr_pkg::DEADBAND_RST;
            cur_cx   = pttr_pkg::CENTRE_X_RST;
            cur_cy   = pttr_pkg::CENTRE_Y_RST;
            pan_pos  = int'(pttr_pkg::ANGLE_HOME);
            tilt_pos = int'(pttr_pkg::ANGLE_HOME);
            servo_cmd_q.delete();
            errors   = 0;
            checked  = 0;
        end else begin
            // result side first: a transaction taken now can't show up at this edge
            if (m_valid && m_ready) begin
                if (servo_cmd_q.size() == 0) begin
                    report_mismatch("result with nothing pending, pan_deg", m_pan_deg, -1);
                end else begin
                    want = servo_cmd_q.pop_front();
                    checked++;
                    if (m_pan_deg !== want.pan_deg)
                        report_mismatch("pan_deg", m_pan_deg, want.pan_deg);
                    if (m_tilt_deg !== want.tilt_deg)
                        report_mismatch("tilt_deg", m_tilt_deg, want.tilt_deg);
                    if (m_pan_high_us !== want.pan_high_us)
                        report_mismatch("pan_high_us", m_pan_high_us, want.pan_high_us);
                    if (m_tilt_high_us !== want.tilt_high_us)
                        report_mismatch("tilt_high_us", m_tilt_high_us, want.tilt_high_us);
                    if (m_pan_pulses !== want.pan_pulses)
                        report_mismatch("pan_pulses", m_pan_pulses, want.pan_pulses);
                    if (m_tilt_pulses !== want.tilt_pulses)
                        report_mismatch("tilt_pulses", m_tilt_pulses, want.tilt_pulses);
                end
            end

            if (s_valid && s_ready) begin
                pan_new  = next_angle(int'(s_target_x), int'(cur_cx), int'(cur_band),
                                      int'(cur_step), pan_pos);
                tilt_new = next_angle(int'(s_target_y), int'(cur_cy), int'(cur_band),
                                      int'(cur_step), tilt_pos);
                cmd.pan_deg      = pttr_pkg::ANGLE_W'(pan_new);
                cmd.tilt_deg     = pttr_pkg::ANGLE_W'(tilt_new);
                cmd.pan_high_us  = servo_high_us(pan_new);
                cmd.tilt_high_us = servo_high_us(tilt_new);
                cmd.pan_pulses   = move_pulses(pan_pos, pan_new);
                cmd.tilt_pulses  = move_pulses(tilt_pos, tilt_new);
                servo_cmd_q.push_back(cmd);
                pan_pos  = pan_new;
                tilt_pos = tilt_new;
            end

            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    pttr_pkg::REG_STEP_SIZE: cur_step = pwdata[pttr_pkg::STEP_W-1:0];
                    pttr_pkg::REG_DEADBAND:  cur_band = pwdata[pttr_pkg::DB_W-1:0];
                    pttr_pkg::REG_CENTRE_X:  cur_cx   = pwdata[pttr_pkg::CENTRE_W-1:0];
                    pttr_pkg::REG_CENTRE_Y:  cur_cy   = pwdata[pttr_pkg::CENTRE_W-1:0];
                    default: ;
                endcase
            end
        end
        pending         <= servo_cmd_q.size();
        fail_count      <= errors;
        results_checked <= checked;
    end

endmodule

>>> tb/pan_tilt_deadband_tracker_core_tb.sv
// Testbench top: clock, reset, target and register stimulus, result back-pressure, verdict.
`timescale 1ns / 100ps

module pan_tilt_deadband_tracker_core_tb;

    localparam int COORD_BITS  = pttr_pkg::COORD_BITS_DEF;
    localparam int COORD_MAX   = (1 << COORD_BITS) - 1;
    // watchdog limit, far beyond the length of the slowest correct run
    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEMS_PER_PHASE = 250;

    logic                            aclk;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    logic [COORD_BITS-1:0]           s_target_x;
    logic [COORD_BITS-1:0]           s_target_y;
    logic                            m_valid;
    logic                            m_ready;
    logic [pttr_pkg::ANGLE_W-1:0]    m_pan_deg;
    logic [pttr_pkg::ANGLE_W-1:0]    m_tilt_deg;
    logic [pttr_pkg::HIGH_W-1:0]     m_pan_high_us;
    logic [pttr_pkg::HIGH_W-1:0]     m_tilt_high_us;
    logic [pttr_pkg::PULSE_W-1:0]    m_pan_pulses;
    logic [pttr_pkg::PULSE_W-1:0]    m_tilt_pulses;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [pttr_pkg::ADDR_W-1:0]     paddr;
    logic [pttr_pkg::DATA_W-1:0]     pwdata;
    logic [pttr_pkg::DATA_W-1:0]     prdata;
    logic                            pready;

    int pending;
    int fail_count;
    int results_checked;
    int cycle_count = 0;
    int targets_sent;
    int reg_writes;
    // percent of cycles in which each side holds off
    int src_idle_pct;
    int snk_idle_pct;

    pan_tilt_deadband_tracker_core #(
        .COORD_BITS(COORD_BITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_target_x     (s_target_x),
        .s_target_y     (s_target_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pan_deg      (m_pan_deg),
        .m_tilt_deg     (m_tilt_deg),
        .m_pan_high_us  (m_pan_high_us),
        .m_tilt_high_us (m_tilt_high_us),
        .m_pan_pulses   (m_pan_pulses),
        .m_tilt_pulses  (m_tilt_pulses),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    pan_tilt_deadband_tracker_checker #(
        .COORD_BITS(COORD_BITS)
    ) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_target_x      (s_target_x),
        .s_target_y      (s_target_y),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pan_deg       (m_pan_deg),
        .m_tilt_deg      (m_tilt_deg),
        .m_pan_high_us   (m_pan_high_us),
        .m_tilt_high_us  (m_tilt_high_us),
        .m_pan_pulses    (m_pan_pulses),
        .m_tilt_pulses   (m_tilt_pulses),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pending         (pending),
        .fail_count      (fail_count),
        .results_checked (results_checked)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side back-pressure: a fresh coin toss every cycle at the current stall rate.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Watchdog: a hang anywhere (lost result, stuck ready) ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still pending",
                     cycle_count, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // One target transaction. Called right after a rising edge. An optional
    // gap comes first; valid is lowered once for it and raised once after it,
    // so it never gets two updates in one step. Returns once the transaction
    // has been taken.
    task automatic send_target(input logic [COORD_BITS-1:0] x,
                               input logic [COORD_BITS-1:0] y);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_valid    <= 1'b1;
        s_target_x <= x;
        s_target_y <= y;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        targets_sent++;
    endtask

    // Register write: setup cycle, then access cycle; the write lands at the
    // edge where psel, penable, pwrite and pready are all high.
    task automatic cfg_write(input logic [pttr_pkg::IDX_W-1:0] idx,
                             input logic [pttr_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
    endtask

    // Drop valid and wait until every predicted result has come back, then let
    // the two-stage pipe settle. The first edge lets the checker's
    // pending count catch up with a transaction taken at the current edge.
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_tracking(input logic [pttr_pkg::STEP_W-1:0] step,
                                input logic [pttr_pkg::DB_W-1:0] band,
                                input logic [pttr_pkg::CENTRE_W-1:0] cx,
                                input logic [pttr_pkg::CENTRE_W-1:0] cy);
        cfg_write(pttr_pkg::REG_STEP_SIZE, pttr_pkg::DATA_W'(step));
        cfg_write(pttr_pkg::REG_DEADBAND,  pttr_pkg::DATA_W'(band));
        cfg_write(pttr_pkg::REG_CENTRE_X,  pttr_pkg::DATA_W'(cx));
        cfg_write(pttr_pkg::REG_CENTRE_Y,  pttr_pkg::DATA_W'(cy));
    endtask

    // Most targets land around the deadband edges so both directions and the
    // hold case all get hit; the rest span the full coordinate range.
    function automatic logic [COORD_BITS-1:0] aim_near(input int centre, input int band);
        int v;
        if ($urandom_range(0, 99) < 35) return COORD_BITS'($urandom_range(0, COORD_MAX));
        v = centre - band - 24 + int'($urandom_range(0, 2 * band + 48));
        if (v < 0) v = 0;
        if (v > COORD_MAX) v = COORD_MAX;
        return COORD_BITS'(v);
    endfunction

    task automatic run_phase(input int src_pct, input int snk_pct,
                             input int step_lo, input int step_hi, input int band_hi);
        logic [pttr_pkg::STEP_W-1:0]   step;
        logic [pttr_pkg::DB_W-1:0]     band;
        logic [pttr_pkg::CENTRE_W-1:0] cx;
        logic [pttr_pkg::CENTRE_W-1:0] cy;
        wait_idle();
        step = pttr_pkg::STEP_W'($urandom_range(step_lo, step_hi));
        band = pttr_pkg::DB_W'($urandom_range(0, band_hi));
        cx   = pttr_pkg::CENTRE_W'($urandom_range(0, COORD_MAX));
        cy   = pttr_pkg::CENTRE_W'($urandom_range(0, COORD_MAX));
        set_tracking(step, band, cx, cy);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        repeat (ITEMS_PER_PHASE) begin
            send_target(aim_near(int'(cx), int'(band)), aim_near(int'(cy), int'(band)));
        end
    endtask

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_target_x   = '0;
        s_target_y   = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        targets_sent = 0;
        reg_writes   = 0;
        src_idle_pct = 29;
        snk_idle_pct = 76;

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // --- directed part, reset config: step 3, deadband 20, centre 640/360 ---
        send_target(12'd640, 12'd360);       // dead centre, both hold
        send_target(12'd660, 12'd380);       // exactly on the upper edge, still hold
        send_target(12'd661, 12'd381);       // one past: both step up
        send_target(12'd620, 12'd340);       // exactly on the lower edge, hold
        send_target(12'd619, 12'd339);       // one past: both step down
        send_target(12'd0, 12'd0);
        send_target(12'hFFF, 12'hFFF);
        send_target(12'd0, 12'hFFF);
        send_target(12'hFFF, 12'd0);

        // full-range step and zero deadband, centres at the opposite edges:
        // pan pinned at 180, tilt at 0, then the unreachable directions
        wait_idle();
        set_tracking(8'd180, 8'd0, 12'd0, 12'hFFF);
        send_target(12'hFFF, 12'd0);         // saturate both
        send_target(12'hFFF, 12'd0);         // clipped step, no movement
        send_target(12'd0, 12'hFFF);         // below 0 / above max: can't trigger
        send_target(12'd1, 12'd4094);

        // swap centre edges: full 180 degree swing on both axes
        wait_idle();
        cfg_write(pttr_pkg::REG_CENTRE_X, pttr_pkg::DATA_W'(COORD_MAX));
        cfg_write(pttr_pkg::REG_CENTRE_Y, '0);
        send_target(12'd0, 12'hFFF);

        // zero step: targets everywhere, angles never move
        wait_idle();
        cfg_write(pttr_pkg::REG_STEP_SIZE, '0);
        send_target(12'hFFF, 12'd0);
        send_target(12'd0, 12'hFFF);

        // step and deadband at their maximum, centre mid-frame
        wait_idle();
        set_tracking(8'd255, 8'd255, 12'd2048, 12'd2048);
        send_target(12'd2304, 12'd2304);
        send_target(12'd1792, 12'd1792);
        send_target(12'd2303, 12'd1793);     // both on the band edges

        // single degree steps: smallest non-zero pulse count
        wait_idle();
        set_tracking(8'd1, 8'd0, 12'd100, 12'd200);
        send_target(12'd101, 12'd199);
        send_target(12'd99, 12'd201);

        // --- random part, three pacing phases with fresh settings each ---
        run_phase(29, 76, 1, 9, 60);
        run_phase(76, 29, 0, 255, 255);
        run_phase(0, 0, 1, 6, 30);

        wait_idle();
        repeat (4) @(posedge aclk);

        $display("Run covered %0d target transactions and %0d checked results", targets_sent,
                 results_checked);
        $display("over %0d register writes, edge cases plus three pacing phases", reg_writes);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
